### src/adclz_pkg.sv
// Shared types and constants for the ADC LZ decompressor.
// Used by the controller, the datapath and the top level; no dependencies.
package adclz_pkg;

   localparam int HIST_DEPTH = 65536;
   localparam int HIST_AW    = 16;

   localparam logic [6:0] MAX_COPY_LEN = 7'd67;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_DIST  = 2'd1;
   localparam logic [1:0] STAT_TRUNC = 2'd2;

   typedef enum logic [1:0] {
      PH_CMD,
      PH_LIT,
      PH_DHI,
      PH_DLO
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_READ,
      S_WRITE,
      S_FLUSH,
      S_FINAL
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_b0;
      logic [7:0] out_b1;
      logic [7:0] out_b2;
      logic [7:0] out_b3;
      logic [2:0] byte_count;
      logic       run_last;
      logic       chunk_done;
      logic [1:0] status;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic eval;
      logic rd;
      logic wr;
      logic emit;
      logic last;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic eval_copy;
      logic eval_final;
      logic copy_last;
      logic pack_three;
      logic out_free;
   } stat_type;

endpackage

### src/adclz_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module adclz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/adclz_datapath.sv
// Datapath of the ADC LZ decompressor: decode registers, history RAM, packing
// buffer and output register. Depends on adclz_pkg and adclz_ram.
module adclz_datapath #(
   parameter int WINDOW_BYTES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  adclz_pkg::req_type req_data,
   input  adclz_pkg::cmd_type cmd,
   output adclz_pkg::stat_type status,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output adclz_pkg::rsp_type rsp_data
);
   import adclz_pkg::*;

   localparam int PCW = $clog2(WINDOW_BYTES + 1);
   localparam logic [PCW-1:0] PC_MAX = PCW'(WINDOW_BYTES);

   logic [7:0]         byte_ff, byte_in;
   logic               end_ff, end_in;
   phase_type          phase_ff, phase_in;
   logic [7:0]         lit_left_ff, lit_left_in;
   logic [6:0]         copy_len_ff, copy_len_in;
   logic [7:0]         dist_hi_ff, dist_hi_in;
   logic [15:0]        wpos_ff, wpos_in;
   logic [PCW-1:0]     produced_ff, produced_in;
   logic [15:0]        src_ff, src_in;
   logic [6:0]         remain_ff, remain_in;
   logic               dist_err_ff, dist_err_in;
   logic [7:0]         pack_ff [4];
   logic [7:0]         pack_in [4];
   logic [2:0]         pack_cnt_ff, pack_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [16:0] dist_c;
   logic        dist_err_c;
   logic [6:0]  len_c;
   logic [7:0]  lit_next;
   logic        push;
   logic [7:0]  wdata;
   logic [7:0]  ram_rdata;
   logic [1:0]  stat_c;

   // The distance is one-based; a distance of 65536 wraps to the write position.
   assign dist_c     = {1'b0, dist_hi_ff, byte_ff} + 17'd1;
   assign dist_err_c = PCW'(dist_c) > produced_ff;
   assign len_c      = (copy_len_ff > MAX_COPY_LEN) ? MAX_COPY_LEN : copy_len_ff;
   assign lit_next   = (lit_left_ff != 8'd0) ? lit_left_ff - 8'd1 : 8'd0;

   assign push  = (cmd.eval && phase_ff == PH_LIT) || cmd.wr;
   assign wdata = cmd.wr ? ram_rdata : byte_ff;

   assign stat_c = dist_err_ff ? STAT_DIST :
                   (end_ff && phase_ff != PH_CMD) ? STAT_TRUNC : STAT_OK;

   assign status.eval_copy  = phase_ff == PH_DLO && !dist_err_c && len_c != 7'd0;
   assign status.eval_final = phase_ff == PH_LIT || end_ff ||
                              (phase_ff == PH_DLO && !status.eval_copy);
   assign status.copy_last  = remain_ff == 7'd1;
   assign status.pack_three = pack_cnt_ff == 3'd3;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   adclz_ram #(
      .WIDTH (8),
      .DEPTH (HIST_DEPTH)
   ) u_hist (
      .clock (clock),
      .we    (push),
      .waddr (wpos_ff),
      .wdata (wdata),
      .re    (cmd.rd),
      .raddr (src_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      byte_in      = byte_ff;
      end_in       = end_ff;
      phase_in     = phase_ff;
      lit_left_in  = lit_left_ff;
      copy_len_in  = copy_len_ff;
      dist_hi_in   = dist_hi_ff;
      wpos_in      = wpos_ff;
      produced_in  = produced_ff;
      src_in       = src_ff;
      remain_in    = remain_ff;
      dist_err_in  = dist_err_ff;
      pack_in      = pack_ff;
      pack_cnt_in  = pack_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         byte_in = req_data.in_byte;
         end_in  = req_data.chunk_end;
      end

      if (cmd.eval) begin
         case (phase_ff)
            PH_CMD: begin
               if (byte_ff[7]) begin
                  lit_left_in = {1'b0, byte_ff[6:0]} + 8'd1;
                  phase_in    = PH_LIT;
               end else if (byte_ff[6]) begin
                  copy_len_in = {1'b0, byte_ff[5:0]} + 7'd4;
                  phase_in    = PH_DHI;
               end else begin
                  copy_len_in = {3'b000, byte_ff[5:2]} + 7'd3;
                  dist_hi_in  = {6'b000000, byte_ff[1:0]};
                  phase_in    = PH_DLO;
               end
            end
            PH_LIT: begin
               lit_left_in = lit_next;
               phase_in    = (lit_next == 8'd0) ? PH_CMD : PH_LIT;
            end
            PH_DHI: begin
               dist_hi_in = byte_ff;
               phase_in   = PH_DLO;
            end
            default: begin
               phase_in    = PH_CMD;
               copy_len_in = 7'd0;
               dist_err_in = dist_err_c;
               remain_in   = dist_err_c ? 7'd0 : len_c;
               src_in      = wpos_ff - dist_c[15:0];
            end
         endcase
      end

      if (cmd.rd) begin
         src_in = src_ff + 16'd1;
      end

      if (push) begin
         wpos_in = wpos_ff + 16'd1;
         if (produced_ff < PC_MAX) begin
            produced_in = produced_ff + PCW'(1);
         end
         pack_in[pack_cnt_ff[1:0]] = wdata;
         pack_cnt_in = pack_cnt_ff + 3'd1;
      end

      if (cmd.wr) begin
         remain_in = remain_ff - 7'd1;
      end

      if (cmd.emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_b0     = (pack_cnt_ff > 3'd0) ? pack_ff[0] : 8'd0;
         rsp_data_in.out_b1     = (pack_cnt_ff > 3'd1) ? pack_ff[1] : 8'd0;
         rsp_data_in.out_b2     = (pack_cnt_ff > 3'd2) ? pack_ff[2] : 8'd0;
         rsp_data_in.out_b3     = (pack_cnt_ff > 3'd3) ? pack_ff[3] : 8'd0;
         rsp_data_in.byte_count = pack_cnt_ff;
         rsp_data_in.run_last   = cmd.last;
         rsp_data_in.chunk_done = cmd.last && end_ff;
         rsp_data_in.status     = cmd.last ? stat_c : STAT_OK;
         pack_cnt_in            = 3'd0;
         if (cmd.last) begin
            dist_err_in = 1'b0;
            // The history is forgotten once the chunk closes.
            if (end_ff) begin
               wpos_in     = 16'd0;
               produced_in = '0;
               phase_in    = PH_CMD;
               lit_left_in = 8'd0;
               copy_len_in = 7'd0;
               dist_hi_in  = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CMD;
         lit_left_ff  <= 8'd0;
         copy_len_ff  <= 7'd0;
         dist_hi_ff   <= 8'd0;
         wpos_ff      <= 16'd0;
         produced_ff  <= '0;
         src_ff       <= 16'd0;
         remain_ff    <= 7'd0;
         dist_err_ff  <= 1'b0;
         pack_cnt_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         lit_left_ff  <= lit_left_in;
         copy_len_ff  <= copy_len_in;
         dist_hi_ff   <= dist_hi_in;
         wpos_ff      <= wpos_in;
         produced_ff  <= produced_in;
         src_ff       <= src_in;
         remain_ff    <= remain_in;
         dist_err_ff  <= dist_err_in;
         pack_cnt_ff  <= pack_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      end_ff      <= end_in;
      pack_ff     <= pack_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded while the output register was still occupied");

   a_copy_not_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> remain_ff != 7'd0)
      else $error("copy wrote a byte beyond its length");

   a_pack_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> pack_cnt_ff < 3'd4)
      else $error("packing buffer overflow");

   a_partial_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.run_last) |-> rsp_data_ff.byte_count == 3'd4)
      else $error("a non-final transaction carries fewer than four bytes");

   a_dist_err_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STAT_DIST) |-> rsp_data_ff.byte_count == 3'd0)
      else $error("a rejected copy produced bytes");

endmodule

### src/adclz_ctrl.sv
// Sequencing state machine of the ADC LZ decompressor.
// Depends on adclz_pkg; drives the datapath through cmd_type and reads stat_type.
module adclz_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  adclz_pkg::stat_type status,
   output adclz_pkg::cmd_type  cmd
);
   import adclz_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (status.eval_copy) begin
               state_in = S_READ;
            end else if (status.eval_final) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr = 1'b1;
            if (status.copy_last) begin
               state_in = S_FINAL;
            end else if (status.pack_three) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_READ;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_READ;
            end
         end
         S_FINAL: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### src/adc_lz_decompressor.sv
// ADC LZ decompressor: takes one compressed byte per transaction and returns the
// decoded bytes packed up to four per result transaction. Each copied byte is
// read from the registered-read history RAM in S_READ and then written in
// S_WRITE, so that overlapping copies see their own output; every fourth copied
// byte before the last passes through S_FLUSH to emit a full result. A chunk end
// on a byte that decodes nothing still passes through S_FINAL for its closing
// result. A result that waits in the output register stalls the flush and final
// states. A new compressed byte is taken while the last result still waits in the
// output register. After reset the block is ready at once; history bytes never
// written in the current chunk are never read, since such copies are rejected
// with status 1.
// Depends on adclz_pkg, adclz_ctrl, adclz_datapath and adclz_ram.
module adc_lz_decompressor #(
   parameter int WINDOW_BYTES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  adclz_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output adclz_pkg::rsp_type rsp_data
);
   import adclz_pkg::*;

   cmd_type  cmd;
   stat_type status;

   adclz_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   adclz_datapath #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
